FILE: rtl/s5s_pkg.sv
`timescale 1ns / 1ps
// s5s_pkg: shared types and constants for the _S5_ sleep type scanner
// no dependencies
package s5s_pkg;

  localparam int unsigned LEN_BITS   = 20;
  localparam int unsigned SCAN_BYTES = 18;

  localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
  localparam logic [7:0] CH_S          = 8'h53;
  localparam logic [7:0] CH_FIVE       = 8'h35;
  localparam logic [7:0] OP_PACKAGE    = 8'h12;
  localparam logic [7:0] OP_ZERO       = 8'h00;
  localparam logic [7:0] OP_ONE        = 8'h01;
  localparam logic [7:0] OP_BYTE       = 8'h0a;
  localparam logic [7:0] OP_WORD       = 8'h0b;
  localparam logic [7:0] OP_DWORD      = 8'h0c;
  localparam logic [7:0] PKGLEN_MASK1  = 8'h3f;
  localparam logic [7:0] PKGLEN_MASKN  = 8'h0f;

  localparam logic [0:0] REG_BODY_LENGTH = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_DONE
  } s5s_state_t;

  typedef struct packed {
    logic accept;
    logic flush_step;
    logic load_out;
  } s5s_cmd_t;

  typedef struct packed {
    logic last_byte;
  } s5s_stat_t;

  typedef struct packed {
    logic        ok;
    logic [2:0]  used;
    logic [15:0] val;
  } s5s_int_t;

endpackage

FILE: rtl/s5s_match.sv
`timescale 1ns / 1ps
// s5s_match: tests one start position of the window for an _S5_ package
// depends on s5s_pkg
module s5s_match
  import s5s_pkg::*;
(
  input  logic [SCAN_BYTES-1:0][7:0] win,
  input  logic [LEN_BITS-1:0]        rem,
  output logic                       hit,
  output logic [2:0]                 type_a,
  output logic [2:0]                 type_b
);

  function automatic s5s_int_t read_int(input logic [7:0] op, input logic [7:0] b1,
                                        input logic [7:0] b2, input logic [27:0] room);
    s5s_int_t r;
    r = '0;
    case (op)
      OP_ZERO: begin
        r.ok   = (room != 28'd0);
        r.used = 3'd1;
      end
      OP_ONE: begin
        r.ok   = (room != 28'd0);
        r.used = 3'd1;
        r.val  = 16'd1;
      end
      OP_BYTE: begin
        r.ok   = (room >= 28'd2);
        r.used = 3'd2;
        r.val  = {8'h00, b1};
      end
      OP_WORD: begin
        r.ok   = (room >= 28'd3);
        r.used = 3'd3;
        r.val  = {b2, b1};
      end
      OP_DWORD: begin
        r.ok   = (room >= 28'd5);
        r.used = 3'd5;
        r.val  = {b2, b1};
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  logic [LEN_BITS-1:0] avail;
  logic [1:0]          follow;
  logic [2:0]          hdr;
  logic [27:0]         plen;
  logic [4:0]          cnt_idx;
  logic [4:0]          a_idx;
  logic [4:0]          b_idx;
  logic [27:0]         room_a;
  logic [27:0]         room_b;
  s5s_int_t            rd_a;
  s5s_int_t            rd_b;
  logic                sig_ok;
  logic                len_ok;

  always_comb begin
    avail  = rem - LEN_BITS'(5);
    follow = win[5][7:6];
    hdr    = {1'b0, follow} + 3'd1;
    case (follow)
      2'd0:    plen = {20'd0, win[5] & PKGLEN_MASK1};
      2'd1:    plen = {16'd0, win[6], win[5][3:0]};
      2'd2:    plen = {8'd0, win[7], win[6], win[5][3:0]};
      default: plen = {win[8], win[7], win[6], win[5][3:0]};
    endcase
    cnt_idx = 5'd5 + {2'b00, hdr};
    a_idx   = cnt_idx + 5'd1;
    room_a  = plen - {25'd0, hdr} - 28'd1;
    rd_a    = read_int(win[a_idx], win[a_idx + 5'd1], win[a_idx + 5'd2], room_a);
    b_idx   = a_idx + {2'b00, rd_a.used};
    room_b  = room_a - {25'd0, rd_a.used};
    rd_b    = read_int(win[b_idx], win[b_idx + 5'd1], win[b_idx + 5'd2], room_b);

    sig_ok = (win[0] == CH_UNDERSCORE) && (win[1] == CH_S) && (win[2] == CH_FIVE) &&
             (win[3] == CH_UNDERSCORE) && (win[4] == OP_PACKAGE);
    len_ok = (rem > LEN_BITS'(4)) && (avail != '0) &&
             ((LEN_BITS'(follow) + LEN_BITS'(1)) <= avail) &&
             (plen != 28'd0) && (plen >= ({25'd0, hdr} + 28'd1)) &&
             (plen <= {8'd0, avail});
    hit = sig_ok && len_ok && (win[cnt_idx] >= 8'd2) && rd_a.ok && rd_b.ok &&
          (rd_a.val <= 16'd7) && (rd_b.val <= 16'd7);
    type_a = rd_a.val[2:0];
    type_b = rd_b.val[2:0];
  end

endmodule

FILE: rtl/s5s_datapath.sv
`timescale 1ns / 1ps
// s5s_datapath: byte window, position, start counter, match hold and result register
// depends on s5s_pkg and s5s_match
module s5s_datapath
  import s5s_pkg::*;
#(
  parameter int unsigned WINDOW_BYTES = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  s5s_cmd_t            cmd,
  output s5s_stat_t           stat,
  input  logic [7:0]          aml_byte,
  input  logic [LEN_BITS-1:0] body_length,
  output logic                found,
  output logic [2:0]          slp_typ_a,
  output logic [2:0]          slp_typ_b
);

  logic [WINDOW_BYTES-1:0][7:0] window;
  logic [LEN_BITS-1:0]          position;
  logic [LEN_BITS:0]            start;
  logic                         pending;
  logic                         match_found;
  logic [2:0]                   held_type_a;
  logic [2:0]                   held_type_b;

  logic [LEN_BITS:0]   start_next;
  logic [LEN_BITS-1:0] rem;
  logic                test_en;
  logic                eval_hit;
  logic [2:0]          eval_a;
  logic [2:0]          eval_b;
  logic                take_hit;

  always_comb begin
    stat.last_byte = ({1'b0, position} + 21'd1) >= {1'b0, body_length};
    start_next     = {1'b0, position} - (LEN_BITS + 1)'(WINDOW_BYTES - 1);
    if (!start[LEN_BITS] && ({1'b0, body_length} > start)) begin
      rem = body_length - start[LEN_BITS-1:0];
    end else begin
      rem = '0;
    end
    test_en  = pending || cmd.flush_step;
    take_hit = test_en && !match_found && !start[LEN_BITS] && eval_hit;
  end

  s5s_match u_match (
    .win    (window[SCAN_BYTES-1:0]),
    .rem    (rem),
    .hit    (eval_hit),
    .type_a (eval_a),
    .type_b (eval_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window      <= '0;
      position    <= '0;
      start       <= '0;
      pending     <= 1'b0;
      match_found <= 1'b0;
      held_type_a <= '0;
      held_type_b <= '0;
    end else if (cmd.load_out) begin
      window      <= '0;
      position    <= '0;
      pending     <= 1'b0;
      match_found <= 1'b0;
      held_type_a <= '0;
      held_type_b <= '0;
    end else begin
      if (take_hit) begin
        match_found <= 1'b1;
        held_type_a <= eval_a;
        held_type_b <= eval_b;
      end
      if (cmd.accept) begin
        window <= {aml_byte, window[WINDOW_BYTES-1:1]};
        start  <= start_next;
        if (stat.last_byte) begin
          pending <= 1'b0;
        end else begin
          position <= position + LEN_BITS'(1);
          pending  <= position >= LEN_BITS'(WINDOW_BYTES - 1);
        end
      end else if (cmd.flush_step) begin
        window  <= {8'h00, window[WINDOW_BYTES-1:1]};
        start   <= start + (LEN_BITS + 1)'(1);
        pending <= 1'b0;
      end else begin
        pending <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      found     <= match_found;
      slp_typ_a <= held_type_a;
      slp_typ_b <= held_type_b;
    end
  end

endmodule

FILE: rtl/s5s_ctrl.sv
`timescale 1ns / 1ps
// s5s_ctrl: scan sequencer, end-of-body flush counter and result valid flag
// depends on s5s_pkg
module s5s_ctrl
  import s5s_pkg::*;
#(
  parameter int unsigned WINDOW_BYTES = 20
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  s5s_stat_t stat,
  output s5s_cmd_t  cmd
);

  localparam int unsigned CNT_BITS = $clog2(WINDOW_BYTES);

  s5s_state_t          state;
  s5s_state_t          state_next;
  logic [CNT_BITS-1:0] flush_cnt;
  logic [CNT_BITS-1:0] flush_cnt_next;
  logic                out_valid_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && stat.last_byte) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (flush_cnt == CNT_BITS'(WINDOW_BYTES - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    flush_cnt_next = '0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_FLUSH: begin
        cmd.flush_step = 1'b1;
        flush_cnt_next = flush_cnt + CNT_BITS'(1);
      end
      ST_DONE: begin
        cmd.load_out = !out_valid || out_ready;
        if (cmd.load_out) begin
          out_valid_next = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      flush_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      flush_cnt <= flush_cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

FILE: rtl/acpi_s5_sleep_type_scanner.sv
`timescale 1ns / 1ps
// acpi_s5_sleep_type_scanner: finds the _S5_ package in a streamed aml body
// depends on s5s_pkg, s5s_ctrl and s5s_datapath
// throughput: one byte per cycle while idle; each full window's start is checked next cycle
// final byte: flush steps then test the remaining start positions, one per cycle
// result: after the flush, loaded and flagged valid once any earlier result is taken
// reset: synchronous, clears window, position, match and body_length
module acpi_s5_sleep_type_scanner
  import s5s_pkg::*;
#(
  parameter int unsigned WINDOW_BYTES = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  aml_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        found,
  output logic [2:0]  slp_typ_a,
  output logic [2:0]  slp_typ_b
);

  logic [LEN_BITS-1:0] body_length;
  s5s_cmd_t            cmd;
  s5s_stat_t           stat;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BODY_LENGTH) ? {12'd0, body_length} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      body_length <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_BODY_LENGTH)) begin
      body_length <= pwdata[LEN_BITS-1:0];
    end
  end

  s5s_ctrl #(
    .WINDOW_BYTES (WINDOW_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  s5s_datapath #(
    .WINDOW_BYTES (WINDOW_BYTES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .aml_byte    (aml_byte),
    .body_length (body_length),
    .found       (found),
    .slp_typ_a   (slp_typ_a),
    .slp_typ_b   (slp_typ_b)
  );

endmodule

FILE: rtl/s5s_checker.sv
`timescale 1ns / 1ps
// s5s_checker: port-level assertions for the _S5_ scanner, bound to the top level
// no dependencies
module s5s_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       found,
  input logic [2:0] slp_typ_a,
  input logic [2:0] slp_typ_b
);

  a_reset_clears_result: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(found) &&
    $stable(slp_typ_a) && $stable(slp_typ_b))
    else $error("stalled result changed");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> slp_typ_a == 3'd0 && slp_typ_b == 3'd0)
    else $error("sleep types nonzero without a match");

  a_result_after_flush: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while bytes were being taken");

endmodule

bind acpi_s5_sleep_type_scanner s5s_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .found     (found),
  .slp_typ_a (slp_typ_a),
  .slp_typ_b (slp_typ_b)
);
